// ===== rtl/core/point_segment_distance_sq_defines.svh =====
// Assertion macros for the point to segment distance block.
// The asserting module must have clk_i and rst_ni in scope.
`ifndef POINT_SEGMENT_DISTANCE_SQ_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_SQ_DEFINES_SVH

// Same-cycle implication
`define PSD_ASSERT_IMP(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (c)) \
    else $error("psd: same-cycle check failed");

// Next-cycle implication
`define PSD_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (c)) \
    else $error("psd: next-cycle check failed");

`endif

// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, constants and stage payload types of the point/segment distance
// pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

  localparam int unsigned CoordWidth    = 24;
  localparam int unsigned ParamFracBits = 16;
  localparam int unsigned TIntBits      = 15;
  localparam int unsigned DistWidth     = 52;
  localparam int unsigned NumAxes       = 3;

  localparam int unsigned DiffWidth = CoordWidth + 1;
  localparam int unsigned LenWidth  = 2 * DiffWidth;
  localparam int unsigned DotWidth  = LenWidth + 1;
  localparam int unsigned TWidth    = TIntBits + ParamFracBits;
  localparam int unsigned TsWidth   = TWidth + 1;
  localparam int unsigned ProdWidth = TsWidth + DiffWidth;
  localparam int unsigned ShWidth   = ProdWidth + 1 - ParamFracBits;
  localparam int unsigned DivStages = TWidth;

  typedef logic signed [CoordWidth-1:0] coord_t;
  typedef logic signed [DiffWidth-1:0]  diff_t;
  typedef logic signed [LenWidth-1:0]   sq_t;
  typedef logic        [LenWidth-1:0]   len_t;
  typedef logic        [DistWidth-1:0]  dist_t;

  // Geometry carried through the front, divider and first three back stages
  typedef struct packed {
    coord_t [NumAxes-1:0] p;
    coord_t [NumAxes-1:0] s;
    diff_t  [NumAxes-1:0] d;
    logic                 clamp;
  } geo_t;

  // Divider stage payload
  typedef struct packed {
    geo_t                geo;
    logic                degen;
    logic                neg;
    logic                ovf;
    len_t                den;
    len_t                rem;
    logic [TIntBits-1:0] mag_lo;
    logic [TWidth-1:0]   quo;
  } div_t;

  // Final result
  typedef struct packed {
    coord_t [NumAxes-1:0] c;
    dist_t                dsq;
    logic                 degen;
  } res_t;

endpackage

// ===== rtl/core/psd_if.sv =====
// ----------------------------------------------------------------------------
// psd_if
// Valid/ready channels for query items and result items.
// ----------------------------------------------------------------------------
interface psd_in_if;
  logic            valid;
  logic            ready;
  psd_pkg::coord_t point_x;
  psd_pkg::coord_t point_y;
  psd_pkg::coord_t point_z;
  psd_pkg::coord_t start_x;
  psd_pkg::coord_t start_y;
  psd_pkg::coord_t start_z;
  psd_pkg::coord_t end_x;
  psd_pkg::coord_t end_y;
  psd_pkg::coord_t end_z;
  logic            clamp_enable;

  modport source (output valid, point_x, point_y, point_z, start_x, start_y, start_z,
                  end_x, end_y, end_z, clamp_enable, input ready);
  modport sink (input valid, point_x, point_y, point_z, start_x, start_y, start_z,
                end_x, end_y, end_z, clamp_enable, output ready);
endinterface

interface psd_out_if;
  logic            valid;
  logic            ready;
  psd_pkg::coord_t closest_x;
  psd_pkg::coord_t closest_y;
  psd_pkg::coord_t closest_z;
  psd_pkg::dist_t  distance_squared;
  logic            degenerate;

  modport source (output valid, closest_x, closest_y, closest_z, distance_squared,
                  degenerate, input ready);
  modport sink (input valid, closest_x, closest_y, closest_z, distance_squared,
                degenerate, output ready);
endinterface

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Four stages: differences, products, dot/length sums with degenerate test,
// and quotient overflow check with divider seeding.
// ----------------------------------------------------------------------------
module psd_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  psd_pkg::dist_t       thr_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  psd_pkg::geo_t        data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output psd_pkg::div_t        data_o
);

  localparam int unsigned NStg = 4;
  localparam int unsigned NA   = psd_pkg::NumAxes;
  localparam int unsigned LW   = psd_pkg::LenWidth;
  localparam int unsigned DW   = psd_pkg::DotWidth;
  localparam int unsigned TI   = psd_pkg::TIntBits;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] vin;

  psd_pkg::geo_t                s1_geo_q, s2_geo_q, s3_geo_q;
  psd_pkg::diff_t [NA-1:0]      s1_w_q;
  psd_pkg::sq_t   [NA-1:0]      s2_dd_q, s2_wd_q;
  psd_pkg::len_t                s3_len_q, s3_mag_q;
  logic                         s3_neg_q, s3_degen_q;
  psd_pkg::div_t                s4_q;

  psd_pkg::diff_t [NA-1:0]      s1_w_d;
  psd_pkg::geo_t                s1_geo_d;
  psd_pkg::sq_t   [NA-1:0]      s2_dd_d, s2_wd_d;
  psd_pkg::len_t                s3_len_d, s3_mag_d;
  logic signed [DW-1:0]         dot;
  psd_pkg::div_t                s4_d;

  // Stage handshake: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end
  assign vin     = {v_q[NStg-2:0], valid_i};
  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign data_o  = s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // Stage 1: segment direction and point offset
  always_comb begin
    s1_geo_d = data_i;
    for (int i = 0; i < NA; i++) begin
      s1_geo_d.d[i] = data_i.d[i] - psd_pkg::diff_t'(data_i.s[i]);
      s1_w_d[i]     = psd_pkg::diff_t'(data_i.p[i]) - psd_pkg::diff_t'(data_i.s[i]);
    end
  end

  // Stage 2: squares and offset-direction products
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      s2_dd_d[i] = psd_pkg::sq_t'(s1_geo_q.d[i]) * psd_pkg::sq_t'(s1_geo_q.d[i]);
      s2_wd_d[i] = psd_pkg::sq_t'(s1_w_q[i]) * psd_pkg::sq_t'(s1_geo_q.d[i]);
    end
  end

  // Stage 3: length and dot sums, sign/magnitude split
  always_comb begin
    s3_len_d = '0;
    dot      = '0;
    for (int i = 0; i < NA; i++) begin
      s3_len_d = s3_len_d + psd_pkg::len_t'(s2_dd_q[i]);
      dot      = dot + DW'(s2_wd_q[i]);
    end
    s3_mag_d = dot[DW-1] ? LW'(-dot) : LW'(dot);
  end

  // Stage 4: quotient overflow test and first partial remainder
  always_comb begin
    s4_d        = '0;
    s4_d.geo    = s3_geo_q;
    s4_d.degen  = s3_degen_q;
    s4_d.neg    = s3_neg_q;
    s4_d.den    = s3_len_q;
    s4_d.ovf    = {{TI{1'b0}}, s3_mag_q} >= {s3_len_q, {TI{1'b0}}};
    s4_d.rem    = s3_mag_q >> TI;
    s4_d.mag_lo = s3_mag_q[TI-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      s1_geo_q <= s1_geo_d;
      s1_w_q   <= s1_w_d;
    end
    if (rdy[1]) begin
      s2_geo_q <= s1_geo_q;
      s2_dd_q  <= s2_dd_d;
      s2_wd_q  <= s2_wd_d;
    end
    if (rdy[2]) begin
      s3_geo_q   <= s2_geo_q;
      s3_len_q   <= s3_len_d;
      s3_mag_q   <= s3_mag_d;
      s3_neg_q   <= dot[DW-1];
      s3_degen_q <= psd_pkg::DistWidth'(s3_len_d) <= thr_i;
    end
    if (rdy[3]) begin
      s4_q <= s4_d;
    end
  end

endmodule

// ===== rtl/core/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage, for the
// projection parameter.
// ----------------------------------------------------------------------------
module psd_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  psd_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output psd_pkg::div_t data_o
);

  localparam int unsigned NStg = psd_pkg::DivStages;
  localparam int unsigned LW   = psd_pkg::LenWidth;
  localparam int unsigned TW   = psd_pkg::TWidth;
  localparam int unsigned PF   = psd_pkg::ParamFracBits;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] vin;
  psd_pkg::div_t   din   [NStg];
  psd_pkg::div_t   dnx   [NStg];
  psd_pkg::div_t   dat_q [NStg];

  always_comb begin
    rdy[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end
  assign vin     = {v_q[NStg-2:0], valid_i};
  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign data_o  = dat_q[NStg-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  for (genvar k = 0; k < NStg; k++) begin : g_stage
    localparam int B = TW - 1 - k;
    logic        bin;
    logic [LW:0] trial;
    logic [LW:0] diff;
    logic        ge;

    if (k == 0) begin : g_first
      assign din[k] = data_i;
    end else begin : g_rest
      assign din[k] = dat_q[k-1];
    end

    // Next dividend bit: integer part bits of the magnitude, then zeros
    if (B >= PF) begin : g_mag_bit
      assign bin = din[k].mag_lo[B-PF];
    end else begin : g_zero_bit
      assign bin = 1'b0;
    end

    assign trial = {din[k].rem, bin};
    assign diff  = trial - {1'b0, din[k].den};
    assign ge    = trial >= {1'b0, din[k].den};

    always_comb begin
      dnx[k]     = din[k];
      dnx[k].rem = ge ? diff[LW-1:0] : trial[LW-1:0];
      dnx[k].quo = {din[k].quo[TW-2:0], ge};
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k]) dat_q[k] <= dnx[k];
    end
  end

endmodule

// ===== rtl/core/psd_back.sv =====
// ----------------------------------------------------------------------------
// psd_back
// Five stages: signed/clamped parameter, offset products, rounding and
// saturation of the closest point, error squares, distance sum.
// ----------------------------------------------------------------------------
module psd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  psd_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output psd_pkg::res_t data_o
);

  localparam int unsigned NStg = 5;
  localparam int unsigned NA   = psd_pkg::NumAxes;
  localparam int unsigned CW   = psd_pkg::CoordWidth;
  localparam int unsigned TW   = psd_pkg::TWidth;
  localparam int unsigned TSW  = psd_pkg::TsWidth;
  localparam int unsigned PW   = psd_pkg::ProdWidth;
  localparam int unsigned PF   = psd_pkg::ParamFracBits;
  localparam int unsigned SHW  = psd_pkg::ShWidth;
  localparam int unsigned DSW  = psd_pkg::DistWidth;

  localparam logic signed [TSW-1:0] TOne  = TSW'(1) << PF;
  localparam logic signed [PW:0]    RHalf = (PW + 1)'(1) << (PF - 1);

  typedef logic signed [PW-1:0]  prod_t;
  typedef logic signed [SHW:0]   csum_t;

  logic [NStg-1:0] v_q;
  logic [NStg:0]   rdy;
  logic [NStg-1:0] vin;

  psd_pkg::geo_t              b1_geo_q, b2_geo_q, b3_geo_q;
  logic                       b1_degen_q, b2_degen_q, b3_degen_q, b4_degen_q;
  logic signed [TSW-1:0]      b1_t_q, b1_t_d;
  prod_t [NA-1:0]             b2_prod_q, b2_prod_d;
  psd_pkg::coord_t [NA-1:0]   b3_c_q, b3_c_d, b4_c_q;
  psd_pkg::sq_t    [NA-1:0]   b4_sq_q, b4_sq_d;
  psd_pkg::res_t              b5_q, b5_d;

  logic [TW-1:0]              tmag;
  logic signed [TSW-1:0]      tsgn;
  logic signed [PW:0]         biased [NA];
  csum_t                      csum   [NA];
  psd_pkg::diff_t             err    [NA];

  always_comb begin
    rdy[NStg] = ready_i;
    for (int k = NStg - 1; k >= 0; k--) begin
      rdy[k] = ~v_q[k] | rdy[k+1];
    end
  end
  assign vin     = {v_q[NStg-2:0], valid_i};
  assign ready_o = rdy[0];
  assign valid_o = v_q[NStg-1];
  assign data_o  = b5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (rdy[k]) v_q[k] <= vin[k];
      end
    end
  end

  // Stage 1: saturate, apply sign, optional clamp to [0, 1]
  always_comb begin
    tmag   = data_i.ovf ? {TW{1'b1}} : data_i.quo;
    tsgn   = data_i.neg ? -$signed({1'b0, tmag}) : $signed({1'b0, tmag});
    b1_t_d = tsgn;
    if (data_i.geo.clamp) begin
      if (tsgn < 0) begin
        b1_t_d = '0;
      end else if (tsgn > TOne) begin
        b1_t_d = TOne;
      end
    end
  end

  // Stage 2: offsets along the segment
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      b2_prod_d[i] = prod_t'(b1_t_q) * prod_t'(b1_geo_q.d[i]);
    end
  end

  // Stage 3: round half up, add start, saturate; start point if degenerate
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      biased[i] = (PW + 1)'(b2_prod_q[i]) + RHalf;
      csum[i]   = csum_t'(b2_geo_q.s[i]) + csum_t'($signed(biased[i][PW:PF]));
      if (b2_degen_q) begin
        b3_c_d[i] = b2_geo_q.s[i];
      end else if (csum[i][SHW:CW-1] == {(SHW-CW+2){csum[i][SHW]}}) begin
        b3_c_d[i] = csum[i][CW-1:0];
      end else begin
        b3_c_d[i] = csum[i][SHW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  // Stage 4: squared error per axis
  always_comb begin
    for (int i = 0; i < NA; i++) begin
      err[i]     = psd_pkg::diff_t'(b3_geo_q.p[i]) - psd_pkg::diff_t'(b3_c_q[i]);
      b4_sq_d[i] = psd_pkg::sq_t'(err[i]) * psd_pkg::sq_t'(err[i]);
    end
  end

  // Stage 5: distance sum (three squares never exceed the output range)
  always_comb begin
    b5_d       = '0;
    b5_d.c     = b4_c_q;
    b5_d.degen = b4_degen_q;
    for (int i = 0; i < NA; i++) begin
      b5_d.dsq = b5_d.dsq + DSW'(psd_pkg::len_t'(b4_sq_q[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      b1_geo_q   <= data_i.geo;
      b1_degen_q <= data_i.degen;
      b1_t_q     <= b1_t_d;
    end
    if (rdy[1]) begin
      b2_geo_q   <= b1_geo_q;
      b2_degen_q <= b1_degen_q;
      b2_prod_q  <= b2_prod_d;
    end
    if (rdy[2]) begin
      b3_geo_q   <= b2_geo_q;
      b3_degen_q <= b2_degen_q;
      b3_c_q     <= b3_c_d;
    end
    if (rdy[3]) begin
      b4_degen_q <= b3_degen_q;
      b4_c_q     <= b3_c_q;
      b4_sq_q    <= b4_sq_d;
    end
    if (rdy[4]) begin
      b5_q <= b5_d;
    end
  end

endmodule

// ===== rtl/core/point_segment_distance_sq.sv =====
// Closest point on a 3D line or segment, and the squared distance to it.
// One query per clock cycle while the output is not stalled; each transaction
// passes through 4 front stages (differences, products, sums, overflow
// check), 31 divider stages (one quotient bit of the Q.16 parameter each),
// and 5 back stages (clamp, multiply, round and saturate, square, sum).
// Stalls at the output back-fill empty stages before the input is held.
// ----------------------------------------------------------------------------
// point_segment_distance_sq
// Top level: threshold register, front, divider and back pipeline.
// ----------------------------------------------------------------------------
`include "point_segment_distance_sq_defines.svh"

module point_segment_distance_sq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  psd_pkg::dist_t cfg_wdata_i,
  psd_in_if.sink         in_i,
  psd_out_if.source      out_o
);

  psd_pkg::dist_t thr_q;
  psd_pkg::geo_t  in_geo;
  psd_pkg::div_t  front_data, div_data;
  psd_pkg::res_t  res;
  logic           front_v, div_rdy, div_v, back_rdy;

  // Degenerate threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // Pack the input transaction; d holds the end point until stage 1
  always_comb begin
    in_geo.p[0]  = in_i.point_x;
    in_geo.p[1]  = in_i.point_y;
    in_geo.p[2]  = in_i.point_z;
    in_geo.s[0]  = in_i.start_x;
    in_geo.s[1]  = in_i.start_y;
    in_geo.s[2]  = in_i.start_z;
    in_geo.d[0]  = psd_pkg::diff_t'(in_i.end_x);
    in_geo.d[1]  = psd_pkg::diff_t'(in_i.end_y);
    in_geo.d[2]  = psd_pkg::diff_t'(in_i.end_z);
    in_geo.clamp = in_i.clamp_enable;
  end

  psd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .thr_i   (thr_q),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_geo),
    .valid_o (front_v),
    .ready_i (div_rdy),
    .data_o  (front_data)
  );

  psd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_v),
    .ready_o (div_rdy),
    .data_i  (front_data),
    .valid_o (div_v),
    .ready_i (back_rdy),
    .data_o  (div_data)
  );

  psd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_v),
    .ready_o (back_rdy),
    .data_i  (div_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.closest_x        = res.c[0];
  assign out_o.closest_y        = res.c[1];
  assign out_o.closest_z        = res.c[2];
  assign out_o.distance_squared = res.dsq;
  assign out_o.degenerate       = res.degen;

  // Input is held only when the whole pipeline is full behind a blocked output
  `PSD_ASSERT_IMP(a_stall_only_full, !in_i.ready, out_o.valid && !out_o.ready)
  // A front item refused by the divider is kept
  `PSD_ASSERT_NEXT(a_front_holds, front_v && !div_rdy, front_v)
  // Threshold write lands
  `PSD_ASSERT_NEXT(a_cfg_write, cfg_we_i, thr_q == $past(cfg_wdata_i))

endmodule
